>>> sv/rdc_pkg.sv
// Shared types and constants for the rotary dial call controller.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package rdc_pkg;

  localparam int MAX_DIGITS_DEF = 32;
  localparam int TIME_W         = 32;
  localparam int GAP_W          = 10;
  localparam int DELAY_W        = 16;
  localparam int DIGIT_W        = 4;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 16;

  localparam logic [GAP_W-1:0]   PULSE_GAP_RST  = 10'd80;
  localparam logic [DELAY_W-1:0] DIAL_DELAY_RST = 16'd3000;
  localparam logic [DIGIT_W-1:0] PULSE_SAT      = 4'd15;
  localparam logic [DIGIT_W-1:0] PULSE_TEN      = 4'd10;

  localparam logic [CFG_IDX_W-1:0] REG_PULSE_GAP  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DIAL_DELAY = 1'b1;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_DIAL  = 2'd1,
    OP_PULSE = 2'd2,
    OP_HOOK  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_DIGIT  = 3'd1,
    ACT_CALL   = 3'd2,
    ACT_TONES  = 3'd3,
    ACT_TEST   = 3'd4,
    ACT_ANSWER = 3'd5,
    ACT_BYE    = 3'd6,
    ACT_LOCAL  = 3'd7
  } action_t;

  localparam logic [1:0] CALL_IDLE      = 2'd0;
  localparam logic [1:0] CALL_PREP      = 2'd1;
  localparam logic [1:0] CALL_CONNECTED = 2'd2;

  localparam logic [1:0] REMOTE_IDLE = 2'd0;
  localparam logic [1:0] REMOTE_RING = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_RD   = 2'd2,
    ST_LD   = 2'd3
  } fsm_t;

  typedef struct packed {
    logic [1:0] operation;
    logic       level;
    logic [1:0] remote_state;
  } in_req_t;

  typedef struct packed {
    logic [2:0]         action;
    logic [DIGIT_W-1:0] digit_value;
    logic [1:0]         local_state;
    logic               last_digit;
  } out_req_t;

endpackage

>>> sv/rdc_digit_mem.sv
// Digit store: single write port, single registered read port.
// Depends on rdc_pkg for the digit width.
`timescale 1ns / 1ps

module rdc_digit_mem #(
  parameter int DEPTH  = rdc_pkg::MAX_DIGITS_DEF,
  parameter int ADDR_W = 5
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [ADDR_W-1:0]           waddr,
  input  logic [rdc_pkg::DIGIT_W-1:0] wdata,
  input  logic                        re,
  input  logic [ADDR_W-1:0]           raddr,
  output logic [rdc_pkg::DIGIT_W-1:0] rdata
);

  logic [rdc_pkg::DIGIT_W-1:0] mem [DEPTH];
  logic [rdc_pkg::DIGIT_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/rdc_ctrl.sv
// Sequencer, timers, call state and output register of the dial controller.
// Depends on rdc_pkg; drives the digit store in rdc_digit_mem.
`timescale 1ns / 1ps

module rdc_ctrl #(
  parameter int MAX_DIGITS = rdc_pkg::MAX_DIGITS_DEF,
  parameter int ADDR_W     = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  rdc_pkg::in_req_t              in_req,
  output logic                          out_valid,
  input  logic                          out_stall,
  output rdc_pkg::out_req_t             out_req,
  input  logic                          cfg_we,
  input  logic [rdc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rdc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output logic                          mem_we,
  output logic [ADDR_W-1:0]             mem_waddr,
  output logic [rdc_pkg::DIGIT_W-1:0]   mem_wdata,
  output logic                          mem_re,
  output logic [ADDR_W-1:0]             mem_raddr,
  input  logic [rdc_pkg::DIGIT_W-1:0]   mem_rdata
);

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DIGITS);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  rdc_pkg::fsm_t                 state_r, state_nxt;
  rdc_pkg::in_req_t              cur_r, cur_nxt;
  logic [rdc_pkg::GAP_W-1:0]     pulse_gap_r, pulse_gap_nxt;
  logic [rdc_pkg::DELAY_W-1:0]   dial_delay_r, dial_delay_nxt;
  logic [rdc_pkg::TIME_W-1:0]    ms_clock_r, ms_clock_nxt;
  logic [rdc_pkg::TIME_W-1:0]    last_pulse_r, last_pulse_nxt;
  logic [rdc_pkg::TIME_W-1:0]    last_dial_r, last_dial_nxt;
  logic [rdc_pkg::DIGIT_W-1:0]   pulse_count_r, pulse_count_nxt;
  logic                          dialing_r, dialing_nxt;
  logic                          dial_pending_r, dial_pending_nxt;
  logic [CNT_W-1:0]              digit_count_r, digit_count_nxt;
  logic [1:0]                    call_state_r, call_state_nxt;
  logic [CNT_W-1:0]              run_len_r, run_len_nxt;
  logic [CNT_W-1:0]              run_idx_r, run_idx_nxt;
  rdc_pkg::action_t              run_act_r, run_act_nxt;
  logic                          out_valid_r, out_valid_nxt;
  rdc_pkg::out_req_t             out_req_r, out_req_nxt;

  logic                          out_free;
  logic [rdc_pkg::TIME_W-1:0]    dial_age;
  logic [rdc_pkg::TIME_W-1:0]    pulse_age;
  logic                          fire;
  logic                          gap_ok;
  logic                          d_valid;
  logic [rdc_pkg::DIGIT_W-1:0]   d_val;
  logic                          room;
  logic                          need_out;
  logic                          run_last;

  assign out_free  = !out_valid_r || !out_stall;
  assign dial_age  = ms_clock_r - last_dial_r;
  assign pulse_age = ms_clock_r - last_pulse_r;
  assign fire      = dial_pending_r && (digit_count_r != '0) &&
                     (dial_age > {{(rdc_pkg::TIME_W-rdc_pkg::DELAY_W){1'b0}}, dial_delay_r});
  assign gap_ok    = pulse_age > {{(rdc_pkg::TIME_W-rdc_pkg::GAP_W){1'b0}}, pulse_gap_r};
  assign d_valid   = (pulse_count_r >= 4'd1) && (pulse_count_r <= rdc_pkg::PULSE_TEN);
  assign d_val     = (pulse_count_r == rdc_pkg::PULSE_TEN) ? '0 : pulse_count_r;
  assign room      = digit_count_r < MAX_CNT;
  assign run_last  = (run_idx_r + CNT_ONE) == run_len_r;

  always_comb begin
    case (rdc_pkg::op_t'(cur_r.operation))
      rdc_pkg::OP_DIAL: need_out = !cur_r.level && room && d_valid;
      rdc_pkg::OP_HOOK: need_out = !cur_r.level ||
                                   (cur_r.remote_state == rdc_pkg::REMOTE_RING);
      default:          need_out = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rdc_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = rdc_pkg::ST_EXEC;
        end
      end
      rdc_pkg::ST_EXEC: begin
        if (rdc_pkg::op_t'(cur_r.operation) == rdc_pkg::OP_TICK) begin
          state_nxt = fire ? rdc_pkg::ST_RD : rdc_pkg::ST_IDLE;
        end else if (!need_out || out_free) begin
          state_nxt = rdc_pkg::ST_IDLE;
        end
      end
      rdc_pkg::ST_RD: state_nxt = rdc_pkg::ST_LD;
      rdc_pkg::ST_LD: begin
        if (out_free) begin
          state_nxt = run_last ? rdc_pkg::ST_IDLE : rdc_pkg::ST_RD;
        end
      end
      default: state_nxt = rdc_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cur_nxt          = cur_r;
    pulse_gap_nxt    = pulse_gap_r;
    dial_delay_nxt   = dial_delay_r;
    ms_clock_nxt     = ms_clock_r;
    last_pulse_nxt   = last_pulse_r;
    last_dial_nxt    = last_dial_r;
    pulse_count_nxt  = pulse_count_r;
    dialing_nxt      = dialing_r;
    dial_pending_nxt = dial_pending_r;
    digit_count_nxt  = digit_count_r;
    call_state_nxt   = call_state_r;
    run_len_nxt      = run_len_r;
    run_idx_nxt      = run_idx_r;
    run_act_nxt      = run_act_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_req_nxt      = out_req_r;
    in_stall         = state_r != rdc_pkg::ST_IDLE;
    mem_we           = 1'b0;
    mem_waddr        = digit_count_r[ADDR_W-1:0];
    mem_wdata        = d_val;
    mem_re           = 1'b0;
    mem_raddr        = run_idx_r[ADDR_W-1:0];

    if (cfg_we) begin
      if (cfg_index == rdc_pkg::REG_PULSE_GAP) begin
        pulse_gap_nxt = cfg_wdata[rdc_pkg::GAP_W-1:0];
      end else begin
        dial_delay_nxt = cfg_wdata[rdc_pkg::DELAY_W-1:0];
      end
    end

    case (state_r)
      rdc_pkg::ST_IDLE: begin
        if (in_valid) begin
          cur_nxt = in_req;
          if (rdc_pkg::op_t'(in_req.operation) == rdc_pkg::OP_TICK) begin
            ms_clock_nxt = ms_clock_r + 32'd1;
          end
        end
      end
      rdc_pkg::ST_EXEC: begin
        if (!need_out || out_free) begin
          case (rdc_pkg::op_t'(cur_r.operation))
            rdc_pkg::OP_TICK: begin
              if (fire) begin
                run_len_nxt      = digit_count_r;
                run_idx_nxt      = '0;
                digit_count_nxt  = '0;
                dial_pending_nxt = 1'b0;
                if (call_state_r == rdc_pkg::CALL_PREP) begin
                  call_state_nxt = rdc_pkg::CALL_CONNECTED;
                  run_act_nxt    = rdc_pkg::ACT_CALL;
                end else if (call_state_r == rdc_pkg::CALL_CONNECTED) begin
                  run_act_nxt = rdc_pkg::ACT_TONES;
                end else begin
                  run_act_nxt = rdc_pkg::ACT_TEST;
                end
              end
            end
            rdc_pkg::OP_DIAL: begin
              dialing_nxt = cur_r.level;
              if (cur_r.level) begin
                pulse_count_nxt = '0;
              end else if (room) begin
                if (d_valid) begin
                  mem_we          = 1'b1;
                  digit_count_nxt = digit_count_r + CNT_ONE;
                  out_valid_nxt   = 1'b1;
                  out_req_nxt     = '{action: rdc_pkg::ACT_DIGIT, digit_value: d_val,
                                      local_state: call_state_r, last_digit: 1'b1};
                end
                last_dial_nxt    = ms_clock_r;
                dial_pending_nxt = 1'b1;
                pulse_count_nxt  = '0;
              end
            end
            rdc_pkg::OP_PULSE: begin
              if (dialing_r && gap_ok) begin
                last_pulse_nxt = ms_clock_r;
                if (pulse_count_r < rdc_pkg::PULSE_SAT) begin
                  pulse_count_nxt = pulse_count_r + 4'd1;
                end
              end
            end
            rdc_pkg::OP_HOOK: begin
              if (cur_r.level) begin
                digit_count_nxt = '0;
                if (cur_r.remote_state == rdc_pkg::REMOTE_RING) begin
                  call_state_nxt = rdc_pkg::CALL_CONNECTED;
                  out_valid_nxt  = 1'b1;
                  out_req_nxt    = '{action: rdc_pkg::ACT_ANSWER, digit_value: '0,
                                     local_state: rdc_pkg::CALL_CONNECTED,
                                     last_digit: 1'b1};
                end else begin
                  call_state_nxt = rdc_pkg::CALL_PREP;
                end
              end else begin
                call_state_nxt = rdc_pkg::CALL_IDLE;
                out_valid_nxt  = 1'b1;
                out_req_nxt    = '{action: ((cur_r.remote_state != rdc_pkg::REMOTE_IDLE) ||
                                            (call_state_r != rdc_pkg::CALL_IDLE)) ?
                                           rdc_pkg::ACT_BYE : rdc_pkg::ACT_LOCAL,
                                   digit_value: '0, local_state: rdc_pkg::CALL_IDLE,
                                   last_digit: 1'b1};
              end
            end
            default: ;
          endcase
        end
      end
      rdc_pkg::ST_RD: begin
        mem_re = 1'b1;
      end
      rdc_pkg::ST_LD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_req_nxt   = '{action: run_act_r, digit_value: mem_rdata,
                            local_state: call_state_r, last_digit: run_last};
          run_idx_nxt   = run_idx_r + CNT_ONE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= rdc_pkg::ST_IDLE;
      pulse_gap_r    <= rdc_pkg::PULSE_GAP_RST;
      dial_delay_r   <= rdc_pkg::DIAL_DELAY_RST;
      ms_clock_r     <= '0;
      last_pulse_r   <= '0;
      last_dial_r    <= '0;
      pulse_count_r  <= '0;
      dialing_r      <= 1'b0;
      dial_pending_r <= 1'b0;
      digit_count_r  <= '0;
      call_state_r   <= rdc_pkg::CALL_IDLE;
      run_len_r      <= '0;
      run_idx_r      <= '0;
      run_act_r      <= rdc_pkg::ACT_NONE;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      pulse_gap_r    <= pulse_gap_nxt;
      dial_delay_r   <= dial_delay_nxt;
      ms_clock_r     <= ms_clock_nxt;
      last_pulse_r   <= last_pulse_nxt;
      last_dial_r    <= last_dial_nxt;
      pulse_count_r  <= pulse_count_nxt;
      dialing_r      <= dialing_nxt;
      dial_pending_r <= dial_pending_nxt;
      digit_count_r  <= digit_count_nxt;
      call_state_r   <= call_state_nxt;
      run_len_r      <= run_len_nxt;
      run_idx_r      <= run_idx_nxt;
      run_act_r      <= run_act_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    out_req_r <= out_req_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_req   = out_req_r;

endmodule

>>> sv/rotary_dial_call_controller.sv
// Rotary dial pulse decoder with call control: top level.
// Depends on rdc_pkg, rdc_ctrl and rdc_digit_mem.
//
// Input channel in_valid/in_stall/in_req carries one event per request: a
// millisecond tick, a dial contact change, a dial pulse edge or a hook change.
// Output channel out_valid/out_stall/out_req carries the resulting actions.
// cfg_we/cfg_index/cfg_wdata write the pulse gap (index 0) and the dial delay
// (index 1); write them only while the block is idle.
// One event is processed at a time: accept, then execute, where an event with
// a result waits while the output register is held; in_stall is high in the
// cycle after acceptance. A digit-stored, answer or hangup result is set in
// the output register from the execute state. A tick that dials the number
// starts a run read from the digit store, one read plus one load per digit,
// bound by the store's read port; each load waits while the output is held.
// The output register holds a request while out_stall is high; the next event
// is still taken and waits in its execute cycle only if it has a result.
// Synchronous reset clears timers, counters and call state and restores the
// configuration defaults; the digit store is not cleared.
`timescale 1ns / 1ps

module rotary_dial_call_controller #(
  parameter int MAX_DIGITS = rdc_pkg::MAX_DIGITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  rdc_pkg::in_req_t               in_req,
  output logic                           out_valid,
  input  logic                           out_stall,
  output rdc_pkg::out_req_t              out_req,
  input  logic                           cfg_we,
  input  logic [rdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rdc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int ADDR_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  logic                        mem_we;
  logic [ADDR_W-1:0]           mem_waddr;
  logic [rdc_pkg::DIGIT_W-1:0] mem_wdata;
  logic                        mem_re;
  logic [ADDR_W-1:0]           mem_raddr;
  logic [rdc_pkg::DIGIT_W-1:0] mem_rdata;

  rdc_ctrl #(
    .MAX_DIGITS(MAX_DIGITS),
    .ADDR_W    (ADDR_W)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_req  (out_req),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_re   (mem_re),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  rdc_digit_mem #(
    .DEPTH (MAX_DIGITS),
    .ADDR_W(ADDR_W)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

endmodule

>>> sv/rdc_checker.sv
// Port-level checks for the rotary dial call controller, bound to the top.
// Depends on rdc_pkg.
`timescale 1ns / 1ps

module rdc_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input rdc_pkg::out_req_t out_req
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_req))
    else $error("stalled output request changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while previous one in execute");

  a_action_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_req.action != rdc_pkg::ACT_NONE &&
                  out_req.local_state != 2'd3)
    else $error("bad action or call state on output");

  a_run_body: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_req.last_digit |->
      out_req.action == rdc_pkg::ACT_CALL || out_req.action == rdc_pkg::ACT_TONES ||
      out_req.action == rdc_pkg::ACT_TEST)
    else $error("non-final result outside a dialed number");

endmodule

bind rotary_dial_call_controller rdc_checker u_rdc_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_req  (out_req)
);

>>> tb/tb_rotary_dial_call_controller.sv
// Self-checking testbench for rotary_dial_call_controller: directed and random
// dial, hook and tick requests checked against an in-bench call tracker.
// Depends on rdc_pkg and the rotary_dial_call_controller RTL.
`timescale 1ns / 1ps

module tb_rotary_dial_call_controller;

  localparam int MAX_DIGITS = rdc_pkg::MAX_DIGITS_DEF;
  localparam int SETTLE     = 80;
  localparam int HOLD_LEN   = 600;
  localparam int WDOG_LIMIT = 20000;

  class call_tracker;
    bit [9:0]          gap_ms;
    bit [15:0]         delay_ms;
    bit [31:0]         ms_now;
    bit [31:0]         last_pulse_ms;
    bit [31:0]         last_return_ms;
    logic [3:0]        pulse_cnt;
    bit                dial_off;
    logic [3:0]        digits [MAX_DIGITS];
    int                n_digits;
    bit                number_waiting;
    logic [1:0]        call_st;
    rdc_pkg::out_req_t due_q [$];
    int                errors;
    int                checked;

    function new();
      gap_ms         = rdc_pkg::PULSE_GAP_RST;
      delay_ms       = rdc_pkg::DIAL_DELAY_RST;
      ms_now         = '0;
      last_pulse_ms  = '0;
      last_return_ms = '0;
      pulse_cnt      = '0;
      dial_off       = 1'b0;
      n_digits       = 0;
      number_waiting = 1'b0;
      call_st        = rdc_pkg::CALL_IDLE;
      errors         = 0;
      checked        = 0;
      foreach (digits[i]) digits[i] = '0;
    endfunction

    function void set_timing(bit [9:0] gap, bit [15:0] delay);
      gap_ms   = gap;
      delay_ms = delay;
    endfunction

    function void due(rdc_pkg::action_t act, logic [3:0] dig, logic last);
      rdc_pkg::out_req_t e;
      e.action      = act;
      e.digit_value = dig;
      e.local_state = call_st;
      e.last_digit  = last;
      due_q.push_back(e);
    endfunction

    function void take_event(rdc_pkg::in_req_t r);
      bit [31:0]        span;
      logic [3:0]       d;
      rdc_pkg::action_t act;
      case (r.operation)
        rdc_pkg::OP_TICK: begin
          ms_now = ms_now + 1;
          span   = ms_now - last_return_ms;
          if (number_waiting && n_digits > 0 && span > delay_ms) begin
            if (call_st == rdc_pkg::CALL_PREP) begin
              call_st = rdc_pkg::CALL_CONNECTED;
              act     = rdc_pkg::ACT_CALL;
            end else if (call_st == rdc_pkg::CALL_CONNECTED) begin
              act = rdc_pkg::ACT_TONES;
            end else begin
              act = rdc_pkg::ACT_TEST;
            end
            for (int i = 0; i < n_digits; i++) due(act, digits[i], i == n_digits - 1);
            n_digits       = 0;
            number_waiting = 1'b0;
          end
        end
        rdc_pkg::OP_DIAL: begin
          dial_off = r.level;
          if (r.level) begin
            pulse_cnt = '0;
          end else if (n_digits < MAX_DIGITS) begin
            if (pulse_cnt >= 1 && pulse_cnt <= rdc_pkg::PULSE_TEN) begin
              d = (pulse_cnt == rdc_pkg::PULSE_TEN) ? 4'd0 : pulse_cnt;
              digits[n_digits] = d;
              n_digits++;
              due(rdc_pkg::ACT_DIGIT, d, 1'b1);
            end
            last_return_ms = ms_now;
            number_waiting = 1'b1;
            pulse_cnt      = '0;
          end
        end
        rdc_pkg::OP_PULSE: begin
          span = ms_now - last_pulse_ms;
          if (dial_off && span > gap_ms) begin
            last_pulse_ms = ms_now;
            if (pulse_cnt < rdc_pkg::PULSE_SAT) pulse_cnt++;
          end
        end
        default: begin
          if (r.level) begin
            n_digits = 0;
            if (r.remote_state == rdc_pkg::REMOTE_RING) begin
              call_st = rdc_pkg::CALL_CONNECTED;
              due(rdc_pkg::ACT_ANSWER, 4'd0, 1'b1);
            end else begin
              call_st = rdc_pkg::CALL_PREP;
            end
          end else begin
            act     = (r.remote_state != rdc_pkg::REMOTE_IDLE ||
                       call_st != rdc_pkg::CALL_IDLE) ? rdc_pkg::ACT_BYE : rdc_pkg::ACT_LOCAL;
            call_st = rdc_pkg::CALL_IDLE;
            due(act, 4'd0, 1'b1);
          end
        end
      endcase
    endfunction

    function void check_action(rdc_pkg::out_req_t got);
      rdc_pkg::out_req_t want;
      checked++;
      if (due_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: action=%0d digit=%0d state=%0d last=%0d",
                   got.action, got.digit_value, got.local_state, got.last_digit);
        return;
      end
      want = due_q.pop_front();
      if (got.action !== want.action || got.digit_value !== want.digit_value ||
          got.local_state !== want.local_state || got.last_digit !== want.last_digit) begin
        errors++;
        if (errors <= 10)
          $display("result mismatch (action/digit/state/last): exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                   want.action, want.digit_value, want.local_state, want.last_digit,
                   got.action, got.digit_value, got.local_state, got.last_digit);
      end
    endfunction

    function int pending();
      return due_q.size();
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  rdc_pkg::in_req_t               in_req;
  logic                           out_valid;
  logic                           out_stall;
  rdc_pkg::out_req_t              out_req;
  logic                           cfg_we;
  logic [rdc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [rdc_pkg::CFG_DATA_W-1:0] cfg_wdata;

  call_tracker      tracker = new();
  rdc_pkg::in_req_t dial_events [$];
  int               pushed;
  int               send_idle_pct;
  int               recv_stall_pct;
  bit               hold_go;
  bit [9:0]         cur_gap;
  bit [15:0]        cur_delay;

  rotary_dial_call_controller uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // request feeder: one offer at a time, idles only between requests
  initial begin : feeder
    bit offering;
    offering = 1'b0;
    in_valid <= 1'b0;
    in_req   <= '0;
    forever begin
      if (!offering) begin
        if (dial_events.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_req   <= dial_events[0];
          offering = 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      @(posedge clk);
      if (offering && !in_stall) begin
        tracker.take_event(dial_events.pop_front());
        offering = 1'b0;
      end
    end
  end

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) tracker.check_action(out_req);
      if (hold_go) begin
        hold_left = HOLD_LEN;
        hold_go   = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("rotary_dial_call_controller: mismatch");
    $finish;
  end

  function automatic logic any_lvl();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic [1:0] any_rem();
    return 2'($urandom_range(0, 3));
  endfunction

  function automatic logic [1:0] any_op();
    return 2'($urandom_range(0, 3));
  endfunction

  task automatic push_ev(input logic [1:0] op, input logic lvl, input logic [1:0] rem);
    rdc_pkg::in_req_t r;
    r.operation    = op;
    r.level        = lvl;
    r.remote_state = rem;
    dial_events.push_back(r);
    pushed++;
  endtask

  task automatic let_feed();
    while (dial_events.size() > 0) @(posedge clk);
  endtask

  task automatic drain();
    let_feed();
    while (tracker.pending() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_timing(input bit [9:0] gap, input bit [15:0] delay);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= rdc_pkg::REG_PULSE_GAP;
    cfg_wdata <= rdc_pkg::CFG_DATA_W'(gap);
    @(posedge clk);
    cfg_index <= rdc_pkg::REG_DIAL_DELAY;
    cfg_wdata <= delay;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_timing(gap, delay);
    cur_gap   = gap;
    cur_delay = delay;
  endtask

  function automatic int pick_pulses();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return $urandom_range(11, 16);
    if (r < 12) return 0;
    return $urandom_range(1, 10);
  endfunction

  // one well-formed dial turn; a short tick spacing now and then drops a pulse
  task automatic dial_digit(input int pulses, input int spacing);
    int sp;
    push_ev(rdc_pkg::OP_DIAL, 1'b1, any_rem());
    repeat (pulses) begin
      sp = ($urandom_range(0, 9) == 0) ? $urandom_range(0, spacing) : spacing;
      repeat (sp) push_ev(rdc_pkg::OP_TICK, any_lvl(), any_rem());
      push_ev(rdc_pkg::OP_PULSE, any_lvl(), any_rem());
    end
    push_ev(rdc_pkg::OP_DIAL, 1'b0, any_rem());
  endtask

  task automatic dial_number(input int n, input bit short_digits);
    int p;
    repeat (n) begin
      p = short_digits ? 1 : pick_pulses();
      dial_digit(p, cur_gap + 1);
    end
    repeat (cur_delay + 1 + $urandom_range(0, 2)) push_ev(rdc_pkg::OP_TICK, 1'b0, any_rem());
  endtask

  task automatic run_segment(input int item_goal, input int result_goal);
    int start_items;
    int start_res;
    int pick;
    start_items = pushed;
    start_res   = tracker.checked;
    while (pushed - start_items < item_goal || tracker.checked - start_res < result_goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        dial_number($urandom_range(1, 4), 1'b0);
      end else if (pick < 85) begin
        push_ev(rdc_pkg::OP_HOOK, 1'b1,
                ($urandom_range(0, 2) == 0) ? rdc_pkg::REMOTE_RING : any_rem());
        if ($urandom_range(0, 1)) dial_number($urandom_range(1, 3), 1'b0);
        push_ev(rdc_pkg::OP_HOOK, 1'b0, any_rem());
      end else begin
        repeat ($urandom_range(1, 4))
          push_ev(any_op(), any_lvl(), any_rem());
      end
      let_feed();
    end
  endtask

  initial begin : stimulus
    pushed         = 0;
    send_idle_pct  = 22;
    recv_stall_pct = 50;
    hold_go        = 1'b0;
    cur_gap        = rdc_pkg::PULSE_GAP_RST;
    cur_delay      = rdc_pkg::DIAL_DELAY_RST;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default timing: hook cases, ignored pulses, empty dial turn
    push_ev(rdc_pkg::OP_HOOK, 1'b0, 2'd0);
    push_ev(rdc_pkg::OP_HOOK, 1'b0, 2'd3);
    push_ev(rdc_pkg::OP_HOOK, 1'b1, 2'd1);
    push_ev(rdc_pkg::OP_HOOK, 1'b0, 2'd0);
    push_ev(rdc_pkg::OP_PULSE, 1'b1, 2'd0);
    push_ev(rdc_pkg::OP_DIAL, 1'b1, 2'd2);
    push_ev(rdc_pkg::OP_PULSE, 1'b0, 2'd1);
    push_ev(rdc_pkg::OP_DIAL, 1'b0, 2'd0);
    push_ev(rdc_pkg::OP_TICK, 1'b1, 2'd2);

    // zero gap and delay: place call, tones, test
    write_timing(10'd0, 16'd0);
    push_ev(rdc_pkg::OP_HOOK, 1'b1, 2'd0);
    dial_digit(1, 1);
    push_ev(rdc_pkg::OP_TICK, 1'b0, 2'd0);
    dial_digit(2, 1);
    push_ev(rdc_pkg::OP_TICK, 1'b0, 2'd3);
    push_ev(rdc_pkg::OP_HOOK, 1'b1, 2'd2);
    push_ev(rdc_pkg::OP_HOOK, 1'b0, 2'd0);
    dial_digit(1, 1);
    push_ev(rdc_pkg::OP_TICK, 1'b1, 2'd1);
    push_ev(rdc_pkg::OP_HOOK, 1'b1, 2'd3);
    push_ev(rdc_pkg::OP_HOOK, 1'b0, 2'd1);

    write_timing(10'($urandom_range(0, 2)), 16'($urandom_range(8, 15)));
    run_segment(25, 3);

    // long number fills the store while the receiver holds off
    send_idle_pct  = 50;
    recv_stall_pct = 22;
    write_timing(10'd0, 16'd20);
    hold_go = 1'b1;
    push_ev(rdc_pkg::OP_HOOK, 1'b1, 2'd0);
    dial_number(MAX_DIGITS + 1, 1'b1);
    let_feed();

    write_timing(10'd1023, 16'hFFFF);
    push_ev(rdc_pkg::OP_HOOK, 1'b1, 2'd0);
    push_ev(rdc_pkg::OP_DIAL, 1'b1, 2'd0);
    repeat (4) push_ev(rdc_pkg::OP_TICK, 1'b0, 2'd0);
    push_ev(rdc_pkg::OP_PULSE, 1'b0, 2'd0);
    push_ev(rdc_pkg::OP_PULSE, 1'b1, 2'd0);
    push_ev(rdc_pkg::OP_DIAL, 1'b0, 2'd0);
    push_ev(rdc_pkg::OP_HOOK, 1'b1, 2'd1);
    push_ev(rdc_pkg::OP_HOOK, 1'b0, 2'd2);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_timing(10'($urandom_range(0, 2)), 16'($urandom_range(8, 15)));
    run_segment(25, 3);

    drain();
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("rotary_dial_call_controller: match");
    end else begin
      $display("rotary_dial_call_controller: mismatch");
    end
    $finish;
  end

endmodule
